// ===== rtl/core/frv_pkg.sv =====
// ----------------------------------------------------------------------------
// frv_pkg
// Shared types, codes and constants of the fragment value reassembler.
// ----------------------------------------------------------------------------
package frv_pkg;

  localparam int DONE_DEPTH_DEFAULT = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int ROWS = 16;
  localparam int MAX_LEN = 47;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [23:0] MAGIC_WORD = 24'h234248;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_MS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_TOKEN     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_TOKEN_MAX = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_TIME      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_NICKNAME  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_AVATAR    = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_IGNORE = 2'd0;
  localparam logic [1:0] ST_MORE   = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  // Front classification of a request.
  localparam logic [1:0] CLS_IGNORE = 2'd0;
  localparam logic [1:0] CLS_ERROR  = 2'd1;
  localparam logic [1:0] CLS_GO     = 2'd2;

  // Value kinds.
  localparam logic [2:0] K_TOKEN     = 3'd0;
  localparam logic [2:0] K_TOKEN_MAX = 3'd1;
  localparam logic [2:0] K_TIME      = 3'd2;
  localparam logic [2:0] K_NICKNAME  = 3'd3;
  localparam logic [2:0] K_AVATAR    = 3'd4;
  localparam logic [2:0] K_UNKNOWN   = 3'd5;

  typedef struct packed {
    logic [23:0] header_magic;
    logic [7:0]  field_code;
    logic [47:0] dest_address;
    logic [15:0] txn;
    logic [7:0]  frag_index;
    logic [7:0]  frag_count;
    logic [7:0]  claimed_len;
    logic [23:0] payload;
    logic        mac_ok;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  value_field;
    logic [15:0] value_txn;
    logic [5:0]  value_len;
    logic [7:0]  value_byte;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [47:0] own_address;
    logic [31:0] timeout_ms;
    logic [7:0]  code_token;
    logic [7:0]  code_token_max;
    logic [7:0]  code_time;
    logic [7:0]  code_nickname;
    logic [7:0]  code_avatar;
  } cfg_t;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    logic [1:0]  cls;
    logic [2:0]  kind;
    logic [7:0]  field;
    logic [15:0] txn;
    logic [3:0]  index;
    logic [4:0]  count;
    logic [5:0]  total;
    logic [23:0] payload;
    logic [31:0] now;
  } work_t;

endpackage

// ===== rtl/core/frv_ram.sv =====
// ----------------------------------------------------------------------------
// frv_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module frv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/frv_front.sv =====
// ----------------------------------------------------------------------------
// frv_front
// Accepts requests and classifies them: header, address, tag, shape, padding.
// ----------------------------------------------------------------------------
module frv_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  frv_pkg::item_t item,
  input  frv_pkg::cfg_t  cfg,
  output logic           push,
  output frv_pkg::work_t push_data,
  input  logic           q_full
);
  import frv_pkg::*;

  logic        fe_valid;
  work_t       fe_q;
  logic [2:0]  kind;
  logic        shape_ok;
  logic        cnt_ok;
  logic        pad_ok;
  logic [9:0]  cnt3;
  logic [9:0]  tot2;
  logic [7:0]  used;
  logic        is_last;
  logic [1:0]  cls;
  logic        accept;

  always_comb begin
    if (item.field_code == cfg.code_token) kind = K_TOKEN;
    else if (item.field_code == cfg.code_token_max) kind = K_TOKEN_MAX;
    else if (item.field_code == cfg.code_time) kind = K_TIME;
    else if (item.field_code == cfg.code_nickname) kind = K_NICKNAME;
    else if (item.field_code == cfg.code_avatar) kind = K_AVATAR;
    else kind = K_UNKNOWN;

    case (kind)
      K_TOKEN, K_TOKEN_MAX, K_TIME: shape_ok = (item.claimed_len == 8'd4);
      K_NICKNAME: shape_ok = (item.claimed_len >= 8'd1) && (item.claimed_len <= 8'd47);
      K_AVATAR:   shape_ok = (item.claimed_len >= 8'd1) && (item.claimed_len <= 8'd15);
      default:    shape_ok = 1'b0;
    endcase

    // count must equal ceil(total / 3): 3*count - 2 <= total <= 3*count.
    cnt3 = 10'(item.frag_count) * 10'd3;
    tot2 = 10'(item.claimed_len) + 10'd2;
    cnt_ok = (item.frag_count != 8'd0) && (item.frag_count <= 8'd16) &&
             (item.frag_index < item.frag_count) &&
             (10'(item.claimed_len) <= cnt3) && (tot2 >= cnt3);

    is_last = (item.frag_index == item.frag_count - 8'd1);
    used = item.claimed_len - 8'(item.frag_index * 8'd3);
    pad_ok = !is_last ||
             (((used >= 8'd2) || (item.payload[15:8] == 8'd0)) &&
              ((used >= 8'd3) || (item.payload[23:16] == 8'd0)));

    if ((item.header_magic != MAGIC_WORD) || (item.dest_address != cfg.own_address)) begin
      cls = CLS_IGNORE;
    end else if (!item.mac_ok || !(shape_ok && cnt_ok && pad_ok)) begin
      cls = CLS_ERROR;
    end else begin
      cls = CLS_GO;
    end
  end

  assign busy = fe_valid && q_full;
  assign accept = start && !busy;
  assign push = fe_valid && !q_full;
  assign push_data = fe_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
    end else if (accept) begin
      fe_valid <= 1'b1;
    end else if (push) begin
      fe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fe_q.cls     <= cls;
      fe_q.kind    <= kind;
      fe_q.field   <= item.field_code;
      fe_q.txn     <= item.txn;
      fe_q.index   <= item.frag_index[3:0];
      fe_q.count   <= item.frag_count[4:0];
      fe_q.total   <= item.claimed_len[5:0];
      fe_q.payload <= item.payload;
      fe_q.now     <= item.now_ms;
    end
  end

endmodule

// ===== rtl/core/frv_queue.sv =====
// ----------------------------------------------------------------------------
// frv_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module frv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  frv_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output frv_pkg::work_t pop_data
);
  import frv_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  work_t            entries [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   fill;

  assign full = (fill == QCW'(QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCW'(1);
      end else if (pop && !push) begin
        fill <= fill - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/frv_back.sv =====
// ----------------------------------------------------------------------------
// frv_back
// Sequencer: done ring search, timeout, assembly, validation and emission.
// ----------------------------------------------------------------------------
module frv_back #(
  parameter int DONE_DEPTH = frv_pkg::DONE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  frv_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  frv_pkg::work_t   q_data,
  output logic             pop,
  output logic             result_valid,
  output frv_pkg::result_t result
);
  import frv_pkg::*;

  localparam int AW = (DONE_DEPTH > 1) ? $clog2(DONE_DEPTH) : 1;
  localparam int FW = $clog2(DONE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SREQ  = 4'd1;
  localparam logic [3:0] S_SCMP  = 4'd2;
  localparam logic [3:0] S_ASM   = 4'd3;
  localparam logic [3:0] S_ACMP  = 4'd4;
  localparam logic [3:0] S_VREQ  = 4'd5;
  localparam logic [3:0] S_VBYTE = 4'd6;
  localparam logic [3:0] S_VEND  = 4'd7;
  localparam logic [3:0] S_EREQ  = 4'd8;
  localparam logic [3:0] S_EBYTE = 4'd9;

  logic [3:0]    state;
  work_t         w;
  logic          assembling;
  logic [7:0]    cur_field;
  logic [15:0]   cur_txn;
  logic [4:0]    cur_count;
  logic [5:0]    cur_total;
  logic [15:0]   got_mask;
  logic [31:0]   last_time;
  logic [AW-1:0] done_ptr;
  logic [FW-1:0] done_fill;
  logic [AW-1:0] sidx;
  logic [3:0]    row;
  logic [1:0]    col;
  logic [5:0]    k;
  logic          ok;
  logic          word_nz;
  logic [1:0]    need;
  logic [20:0]   cp;
  logic [16:0]   cp_lo;

  logic          vs_we;
  logic          vs_re;
  logic [3:0]    vs_raddr;
  logic [23:0]   vs_rdata;
  logic          dr_we;
  logic          dr_re;
  logic [23:0]   dr_rdata;

  logic [31:0]   elapsed;
  logic          timed_out;
  logic          fresh;
  logic [15:0]   bit_sel;
  logic [15:0]   mask_new;
  logic [15:0]   full_mask;
  logic [7:0]    c;
  logic          c_name_ok;
  logic [20:0]   cp_cont;
  logic          byte_last;

  frv_ram #(.WIDTH(24), .DEPTH(ROWS)) u_value_store (
    .clk   (clk),
    .we    (vs_we),
    .waddr (w.index),
    .wdata (w.payload),
    .re    (vs_re),
    .raddr (vs_raddr),
    .rdata (vs_rdata)
  );

  frv_ram #(.WIDTH(24), .DEPTH(DONE_DEPTH)) u_done_ring (
    .clk   (clk),
    .we    (dr_we),
    .waddr (done_ptr),
    .wdata ({w.field, w.txn}),
    .re    (dr_re),
    .raddr (sidx),
    .rdata (dr_rdata)
  );

  always_comb begin
    elapsed = w.now - last_time;
    timed_out = assembling && (elapsed >= cfg.timeout_ms);
    fresh = !assembling || timed_out || (cur_field != w.field) || (cur_txn != w.txn);
    bit_sel = 16'(17'd1 << w.index);
    mask_new = got_mask | bit_sel;
    full_mask = 16'((17'd1 << w.count) - 17'd1);
    c = vs_rdata[8*col +: 8];
    c_name_ok = ((c >= "a") && (c <= "z")) || ((c >= "0") && (c <= "9")) ||
                (c == "_") || (c == "-");
    cp_cont = {cp[14:0], c[5:0]};
    byte_last = ((k + 6'd1) == w.total);
    pop = (state == S_IDLE) && q_valid;
    vs_we = (state == S_ACMP) && !got_mask[w.index];
    vs_re = (state == S_ASM) || (state == S_VREQ) || (state == S_EREQ);
    vs_raddr = (state == S_ASM) ? w.index : row;
    dr_re = (state == S_SREQ);
    dr_we = (state == S_EBYTE) && byte_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      assembling <= 1'b0;
      cur_field <= '0;
      cur_txn <= '0;
      cur_count <= '0;
      cur_total <= '0;
      got_mask <= '0;
      last_time <= '0;
      done_ptr <= '0;
      done_fill <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            sidx <= '0;
            if (q_data.cls == CLS_IGNORE) begin
              result_valid <= 1'b1;
              result <= '{ST_IGNORE, 8'd0, 16'd0, 6'd0, 8'd0, 1'b1};
            end else if (q_data.cls == CLS_ERROR) begin
              result_valid <= 1'b1;
              result <= '{ST_ERROR, 8'd0, 16'd0, 6'd0, 8'd0, 1'b1};
            end else if (done_fill == '0) begin
              state <= S_ASM;
            end else begin
              state <= S_SREQ;
            end
          end
        end
        S_SREQ: state <= S_SCMP;
        S_SCMP: begin
          if (dr_rdata == {w.field, w.txn}) begin
            result_valid <= 1'b1;
            result <= '{ST_IGNORE, 8'd0, 16'd0, 6'd0, 8'd0, 1'b1};
            state <= S_IDLE;
          end else if ((FW'(sidx) + FW'(1)) == done_fill) begin
            state <= S_ASM;
          end else begin
            sidx <= sidx + AW'(1);
            state <= S_SREQ;
          end
        end
        S_ASM: begin
          if (fresh) begin
            assembling <= 1'b1;
            cur_field <= w.field;
            cur_txn <= w.txn;
            cur_count <= w.count;
            cur_total <= w.total;
            got_mask <= '0;
            last_time <= w.now;
            state <= S_ACMP;
          end else if ((cur_count != w.count) || (cur_total != w.total)) begin
            assembling <= 1'b0;
            got_mask <= '0;
            cur_count <= '0;
            cur_total <= '0;
            result_valid <= 1'b1;
            result <= '{ST_ERROR, 8'd0, 16'd0, 6'd0, 8'd0, 1'b1};
            state <= S_IDLE;
          end else begin
            last_time <= w.now;
            state <= S_ACMP;
          end
        end
        S_ACMP: begin
          if (got_mask[w.index]) begin
            result_valid <= 1'b1;
            state <= S_IDLE;
            if (vs_rdata != w.payload) begin
              assembling <= 1'b0;
              got_mask <= '0;
              cur_count <= '0;
              cur_total <= '0;
              result <= '{ST_ERROR, 8'd0, 16'd0, 6'd0, 8'd0, 1'b1};
            end else begin
              result <= '{ST_MORE, 8'd0, 16'd0, 6'd0, 8'd0, 1'b1};
            end
          end else begin
            got_mask <= mask_new;
            if (mask_new != full_mask) begin
              result_valid <= 1'b1;
              result <= '{ST_MORE, 8'd0, 16'd0, 6'd0, 8'd0, 1'b1};
              state <= S_IDLE;
            end else begin
              row <= '0;
              col <= '0;
              k <= '0;
              ok <= 1'b1;
              word_nz <= 1'b0;
              need <= '0;
              state <= S_VREQ;
            end
          end
        end
        S_VREQ: begin
          col <= '0;
          state <= S_VBYTE;
        end
        S_VBYTE: begin
          if ((k < 6'd4) && (c != 8'd0)) begin
            word_nz <= 1'b1;
          end
          if ((w.kind == K_AVATAR) && !c_name_ok) begin
            ok <= 1'b0;
          end
          if (w.kind == K_NICKNAME) begin
            if (need == 2'd0) begin
              if (c == 8'd0) begin
                ok <= 1'b0;
              end else if (c[7] == 1'b0) begin
                need <= 2'd0;
              end else if (c[7:5] == 3'b110) begin
                need <= 2'd1;
                cp <= 21'(c[4:0]);
                cp_lo <= 17'h00080;
              end else if (c[7:4] == 4'b1110) begin
                need <= 2'd2;
                cp <= 21'(c[3:0]);
                cp_lo <= 17'h00800;
              end else if (c[7:3] == 5'b11110) begin
                need <= 2'd3;
                cp <= 21'(c[2:0]);
                cp_lo <= 17'h10000;
              end else begin
                ok <= 1'b0;
              end
            end else begin
              if (c[7:6] != 2'b10) begin
                ok <= 1'b0;
              end
              cp <= cp_cont;
              need <= need - 2'd1;
              if ((need == 2'd1) &&
                  ((cp_cont < 21'(cp_lo)) || (cp_cont > 21'h10ffff) ||
                   ((cp_cont >= 21'h00d800) && (cp_cont <= 21'h00dfff)))) begin
                ok <= 1'b0;
              end
            end
          end
          k <= k + 6'd1;
          if (byte_last) begin
            state <= S_VEND;
          end else if (col == 2'd2) begin
            row <= row + 4'd1;
            state <= S_VREQ;
          end else begin
            col <= col + 2'd1;
          end
        end
        S_VEND: begin
          if (!ok || ((w.kind == K_NICKNAME) && (need != 2'd0)) ||
              (((w.kind == K_TOKEN_MAX) || (w.kind == K_TIME)) && !word_nz)) begin
            assembling <= 1'b0;
            got_mask <= '0;
            cur_count <= '0;
            cur_total <= '0;
            result_valid <= 1'b1;
            result <= '{ST_ERROR, 8'd0, 16'd0, 6'd0, 8'd0, 1'b1};
            state <= S_IDLE;
          end else begin
            row <= '0;
            k <= '0;
            state <= S_EREQ;
          end
        end
        S_EREQ: begin
          col <= '0;
          state <= S_EBYTE;
        end
        S_EBYTE: begin
          result_valid <= 1'b1;
          result <= '{ST_DONE, w.field, w.txn, w.total, c, byte_last};
          k <= k + 6'd1;
          if (byte_last) begin
            done_ptr <= (done_ptr == AW'(DONE_DEPTH - 1)) ? '0 : done_ptr + AW'(1);
            if (done_fill != FW'(DONE_DEPTH)) begin
              done_fill <= done_fill + FW'(1);
            end
            assembling <= 1'b0;
            got_mask <= '0;
            cur_count <= '0;
            cur_total <= '0;
            state <= S_IDLE;
          end else if (col == 2'd2) begin
            row <= row + 4'd1;
            state <= S_EREQ;
          end else begin
            col <= col + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w <= q_data;
    end
  end

`ifndef SYNTHESIS
  a_mask_needs_assembly: assert property (@(posedge clk) disable iff (rst)
    !assembling |-> (got_mask == 16'd0))
    else $error("fragment mask set with no open assembly");
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    done_fill <= FW'(DONE_DEPTH))
    else $error("done ring fill count beyond its depth");
  a_single_result_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_DONE) |-> result.last)
    else $error("a lone status result must be marked last");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (result_valid || (state != S_IDLE)))
    else $error("a popped request left no trace");
`endif

endmodule

// ===== rtl/core/fragment_value_reassembler.sv =====
// ----------------------------------------------------------------------------
// fragment_value_reassembler
// Reassembles addressed broadcast values from three-byte fragments.
// ----------------------------------------------------------------------------
// Usage. A request (one fragment) is taken at a rising edge where start is
// high and busy is low. The front stage checks header, address, tag flag,
// shape and padding and hands the request to a two-entry queue;
// the back sequencer pops it and carries it out. Every request yields one
// result with last set, except a completing fragment, which yields one
// result per value byte (status complete) with last on the final byte.
// Results appear on result for exactly one cycle each, marked by
// result_valid; the receiver cannot stall them, so none are ever held back.
// A request that the front classes ignore or error is answered directly;
// any other is first searched for in the done ring, entry by entry, and
// then takes the assembly step. A completing request then walks the value
// twice, once to validate and once to emit, three bytes per value store
// row each pass. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce. A synchronous reset empties the queue,
// closes any open assembly and forgets every completed value; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module fragment_value_reassembler #(
  parameter int DONE_DEPTH = frv_pkg::DONE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  frv_pkg::item_t                      item,
  output logic                                result_valid,
  output frv_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [frv_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [frv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import frv_pkg::*;

  cfg_t  cfg;
  logic  push;
  work_t push_data;
  logic  q_full;
  logic  q_valid;
  logic  pop;
  work_t q_data;

  // Configuration registers; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address <= '0;
      cfg.timeout_ms <= 32'd5000;
      cfg.code_token <= 8'd0;
      cfg.code_token_max <= 8'd1;
      cfg.code_time <= 8'd2;
      cfg.code_nickname <= 8'd3;
      cfg.code_avatar <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_ADDRESS:    cfg.own_address <= cfg_data;
        REG_TIMEOUT_MS:     cfg.timeout_ms <= cfg_data[31:0];
        REG_CODE_TOKEN:     cfg.code_token <= cfg_data[7:0];
        REG_CODE_TOKEN_MAX: cfg.code_token_max <= cfg_data[7:0];
        REG_CODE_TIME:      cfg.code_time <= cfg_data[7:0];
        REG_CODE_NICKNAME:  cfg.code_nickname <= cfg_data[7:0];
        REG_CODE_AVATAR:    cfg.code_avatar <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The front classifies each request as it arrives.
  frv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // The queue lets the front keep taking requests while the back is busy, until the queue fills.
  frv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  // The back does the ring search, assembly, validation and emission.
  frv_back #(.DONE_DEPTH(DONE_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
